[rtl/sbf_pkg.sv]
// Shared types, constants and the small-constant divider of the separable box filter.
`default_nettype none

package sbf_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_W      = 12;
    localparam int SUM_W      = 11;
    localparam int PEND_W     = 16;
    localparam int LIM_W      = 14;
    localparam int TAPS       = 5;
    localparam int MEAN_LINES = 4;
    localparam int RAW_LINES  = 2;
    localparam int MAX_WINDOW = 5;
    localparam bit WIN5_OK    = (MAX_WINDOW >= 5);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SELECT = 2'd2;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH   = 12'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT  = 12'd480;
    localparam logic             RST_WINDOW_SELECT = 1'b1;
    localparam logic [CFG_W-1:0] MIN_FRAME         = 12'd5;

    localparam int RECIP_W = 12;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP3 = 12'd2731;
    localparam logic [RECIP_W-1:0] RECIP5 = 12'd3277;
    localparam int SHIFT3 = 13;
    localparam int SHIFT5 = 14;

    typedef logic [PIX_W-1:0] t_pixel;
    typedef logic [SUM_W-1:0] t_sum;

    // Exact floor division by 3 or 5 for any 11-bit sum, by reciprocal multiply.
    function automatic t_pixel box_div(input t_sum sum, input logic win5);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] quot;
        if (win5) begin
            prod = PROD_W'(sum) * PROD_W'(RECIP5);
            quot = prod >> SHIFT5;
        end else begin
            prod = PROD_W'(sum) * PROD_W'(RECIP3);
            quot = prod >> SHIFT3;
        end
        return t_pixel'(quot);
    endfunction

endpackage

`default_nettype wire

[rtl/sbf_in_if.sv]
// Input channel of the box filter: pixel and drain words.
`default_nettype none

interface sbf_in_if;
    import sbf_pkg::*;

    logic   valid;
    logic   ready;
    logic   req_type;
    t_pixel pixel_in;

    modport source(output valid, output req_type, output pixel_in, input ready);
    modport sink(input valid, input req_type, input pixel_in, output ready);
endinterface

`default_nettype wire

[rtl/sbf_out_if.sv]
// Output channel of the box filter: filtered pixel words.
`default_nettype none

interface sbf_out_if;
    import sbf_pkg::*;

    logic   valid;
    logic   ready;
    t_pixel pixel_out;
    logic   frame_last;

    modport source(output valid, output pixel_out, output frame_last, input ready);
    modport sink(input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

[rtl/sbf_ram.sv]
// Generic simple dual-port RAM with read-first registered read.
`default_nettype none

module sbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // A read and a write to the same address in one cycle return the old word.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

[rtl/sbf_pixel_cell.sv]
// One cell of the horizontal window: holds a pixel and passes it on at each shift.
`default_nettype none

module sbf_pixel_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  sbf_pkg::t_pixel i_pixel,
    output sbf_pkg::t_pixel o_pixel
);
    import sbf_pkg::*;

    t_pixel r_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel <= '0;
        end else if (i_shift) begin
            r_pixel <= i_pixel;
        end
    end

    assign o_pixel = r_pixel;

endmodule

`default_nettype wire

[rtl/separable_box_filter.sv]
// Streaming separable 3x3 / 5x5 box mean over 8-bit grey pixels.
//
// i_pix carries one word per pixel in raster order (req_type pixel), or a drain
// word that flushes the delayed tail once a frame has been fully received.
// o_pix returns filtered pixels in raster order, delayed by R rows and R columns
// (R = 1 or 2), with frame_last on the final pixel; border pixels pass unchanged.
// The configuration port writes frame width, frame height and window size; it is
// to be written while the block is idle, which the block does not enforce; it acts at once.
// Throughput is one word per cycle while the output is not stalled: the horizontal window
// is a row of five pixel cells, and the row-mean lines (four) and raw lines (two) are one
// RAM each, so every word needs one read per RAM and at most one raw and one mean write.
// A result passes through the RAM read stage and then the output register after the
// word that causes it is accepted; a pixel causes the result for the position R rows
// and R columns behind it.
// Reset clears position counters and window cells and sets the configuration to its
// reset values; line RAMs are not cleared and no clearing pass runs. When the receiver
// stalls, the output register holds its word, one more result waits in the RAM read
// stage, and i_pix.ready drops only when both are full.
`default_nettype none

module separable_box_filter #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sbf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sbf_pkg::CFG_W-1:0]       i_cfg_data,
    sbf_in_if.sink                          i_pix,
    sbf_out_if.source                       o_pix
);
    import sbf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    typedef struct packed {
        t_pixel                newest;
        logic                  raw_direct;
        t_pixel                raw_val;
        logic                  raw_slot;
        logic                  border;
        logic [MEAN_LINES-1:0] mask;
        logic                  win5;
        logic                  last;
    } t_stage;

    // Configuration.
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic             r_window_select;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= RST_FRAME_WIDTH;
            r_frame_height  <= RST_FRAME_HEIGHT;
            r_window_select <= RST_WINDOW_SELECT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data;
                CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data;
                CFG_WINDOW_SELECT: r_window_select <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic             win5;
    logic [1:0]       rad;
    logic [2:0]       ksize;
    logic [ROW_W-1:0] eff_w;
    logic [ROW_W-1:0] eff_h;
    logic [LIM_W-1:0] w_x;
    logic [LIM_W-1:0] dly;

    always_comb begin
        win5  = r_window_select && WIN5_OK;
        rad   = win5 ? 2'd2 : 2'd1;
        ksize = win5 ? 3'd5 : 3'd3;
        if (r_frame_width < MIN_FRAME) begin
            eff_w = MIN_FRAME;
        end else if (LIM_W'(r_frame_width) > LIM_W'(MAX_WIDTH)) begin
            eff_w = ROW_W'(MAX_WIDTH);
        end else begin
            eff_w = r_frame_width;
        end
        eff_h = (r_frame_height < MIN_FRAME) ? MIN_FRAME : r_frame_height;
        w_x   = LIM_W'(eff_w);
        dly   = win5 ? (w_x << 1) + LIM_W'(2) : w_x + LIM_W'(1);
    end

    // Position state.
    logic [CW-1:0]     r_in_col,  n_in_col;
    logic [ROW_W-1:0]  r_in_row,  n_in_row;
    logic [CW-1:0]     r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    logic [1:0]        r_in_tag,  n_in_tag;
    logic [1:0]        r_out_tag, n_out_tag;
    logic [PEND_W-1:0] r_pending, n_pending;

    // Handshake and pipeline control.
    logic   r_s1_valid;
    t_stage r_s1;
    t_stage n_s1;
    logic   r_o_valid;
    t_pixel r_o_pixel;
    logic   r_o_last;
    logic   out_free;
    logic   s1_adv;
    logic   acc;
    logic   pix_acc;
    logic   emit;

    assign out_free    = !r_o_valid || o_pix.ready;
    assign s1_adv      = r_s1_valid && out_free;
    assign i_pix.ready = !r_s1_valid || out_free;
    assign acc         = i_pix.valid && i_pix.ready;
    assign pix_acc     = acc && (i_pix.req_type == REQ_PIXEL);

    // Horizontal window: a row of pixel cells, newest in cell 0.
    t_pixel win_q [TAPS];
    t_pixel n_win [TAPS];

    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        if (g == 0) begin : g_head
            sbf_pixel_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (pix_acc),
                .i_pixel (i_pix.pixel_in),
                .o_pixel (win_q[g])
            );
        end else begin : g_link
            sbf_pixel_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (pix_acc),
                .i_pixel (win_q[g-1]),
                .o_pixel (win_q[g])
            );
        end
    end

    // Line RAM ports.
    logic          raw_wslot;
    logic [CW-1:0] raw_waddr;
    logic          mean_we;
    logic [CW-1:0] mean_waddr;
    t_pixel        hmean;
    t_pixel        raw_q  [RAW_LINES];
    t_pixel        mean_q [MEAN_LINES];

    for (genvar g = 0; g < RAW_LINES; g++) begin : g_raw
        sbf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_raw_line (
            .i_clk   (i_clk),
            .i_we    (pix_acc && (raw_wslot == 1'(g))),
            .i_waddr (raw_waddr),
            .i_wdata (win_q[TAPS-1]),
            .i_re    (acc),
            .i_raddr (r_out_col),
            .o_rdata (raw_q[g])
        );
    end

    for (genvar g = 0; g < MEAN_LINES; g++) begin : g_mean
        sbf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mean_line (
            .i_clk   (i_clk),
            .i_we    (mean_we && (r_in_tag == 2'(g))),
            .i_waddr (mean_waddr),
            .i_wdata (hmean),
            .i_re    (acc),
            .i_raddr (r_out_col),
            .o_rdata (mean_q[g])
        );
    end

    // Accept cycle: window update, horizontal mean, addresses and result setup.
    t_sum              hsum;
    logic [PEND_W-1:0] pend_n;
    logic [PEND_W-1:0] age;
    logic              bypass;
    logic [LIM_W-1:0]  oc_x;
    logic [LIM_W-1:0]  ic_x;
    logic [ROW_W:0]    orow_x;
    logic [ROW_W:0]    irow_x;
    logic [ROW_W:0]    h_x;
    logic              out_col_end;
    logic              out_row_end;
    logic              in_col_end;
    logic              in_row_end;
    logic [1:0]        rel;

    always_comb begin
        n_win[0] = pix_acc ? i_pix.pixel_in : win_q[0];
        for (int i = 1; i < TAPS; i++) begin
            n_win[i] = pix_acc ? win_q[i-1] : win_q[i];
        end

        hsum = SUM_W'(n_win[0]) + SUM_W'(n_win[1]) + SUM_W'(n_win[2])
             + (win5 ? SUM_W'(n_win[3]) + SUM_W'(n_win[4]) : '0);
        hmean = box_div(hsum, win5);

        ic_x   = LIM_W'(r_in_col);
        oc_x   = LIM_W'(r_out_col);
        irow_x = {1'b0, r_in_row};
        orow_x = {1'b0, r_out_row};
        h_x    = {1'b0, eff_h};

        // The pixel leaving the window goes to the raw line store.
        if (r_in_col >= CW'(TAPS)) begin
            raw_wslot = r_in_tag[0];
            raw_waddr = r_in_col - CW'(TAPS);
        end else begin
            raw_wslot = ~r_in_tag[0];
            raw_waddr = CW'(w_x - LIM_W'(TAPS) + ic_x);
        end

        mean_we    = pix_acc && (ic_x + LIM_W'(1) >= LIM_W'(ksize));
        mean_waddr = r_in_col - CW'(rad);

        if (pix_acc) begin
            pend_n = (r_pending == '1) ? r_pending : r_pending + PEND_W'(1);
            emit   = pend_n > PEND_W'(dly);
        end else begin
            pend_n = r_pending;
            emit   = acc && (r_in_row == '0) && (r_in_col == '0) && (r_pending != '0);
        end
        age = pend_n - PEND_W'(1);

        bypass = pix_acc && (raw_wslot == r_out_tag[0]) && (raw_waddr == r_out_col);

        n_s1.newest     = pix_acc ? hmean : '0;
        n_s1.raw_direct = (age < PEND_W'(TAPS)) || bypass;
        n_s1.raw_val    = (age < PEND_W'(TAPS)) ? n_win[age[2:0]] : win_q[TAPS-1];
        n_s1.raw_slot   = r_out_tag[0];
        n_s1.border     = (r_out_row < ROW_W'(rad))
                       || (orow_x + (ROW_W+1)'(rad) >= h_x)
                       || (oc_x < LIM_W'(rad))
                       || (oc_x + LIM_W'(rad) >= w_x);
        for (int s = 0; s < MEAN_LINES; s++) begin
            rel          = 2'(s) - r_out_tag + rad;
            n_s1.mask[s] = win5 || (rel < 2'd2);
        end
        n_s1.win5 = win5;

        out_col_end = oc_x + LIM_W'(1) >= w_x;
        out_row_end = orow_x + (ROW_W+1)'(1) >= h_x;
        n_s1.last   = out_col_end && out_row_end;
        in_col_end  = ic_x + LIM_W'(1) >= w_x;
        in_row_end  = irow_x + (ROW_W+1)'(1) >= h_x;

        n_pending = emit ? pend_n - PEND_W'(1) : pend_n;

        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_out_tag = r_out_tag;
        if (emit) begin
            if (out_col_end) begin
                n_out_col = '0;
                n_out_tag = r_out_tag + 2'd1;
                n_out_row = out_row_end ? '0 : r_out_row + ROW_W'(1);
            end else begin
                n_out_col = r_out_col + CW'(1);
            end
        end

        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_in_tag = r_in_tag;
        if (pix_acc) begin
            if (in_col_end) begin
                n_in_col = '0;
                n_in_tag = r_in_tag + 2'd1;
                n_in_row = in_row_end ? '0 : r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_in_tag   <= '0;
            r_out_tag  <= '0;
            r_pending  <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (acc) begin
                r_in_col   <= n_in_col;
                r_in_row   <= n_in_row;
                r_out_col  <= n_out_col;
                r_out_row  <= n_out_row;
                r_in_tag   <= n_in_tag;
                r_out_tag  <= n_out_tag;
                r_pending  <= n_pending;
                r_s1_valid <= emit;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Read stage: line RAM words arrive, vertical sum and final selection.
    t_pixel raw_pix;
    t_sum   vsum;
    t_pixel res;

    always_comb begin
        raw_pix = r_s1.raw_direct ? r_s1.raw_val : raw_q[r_s1.raw_slot];
        vsum    = SUM_W'(r_s1.newest);
        for (int s = 0; s < MEAN_LINES; s++) begin
            vsum = vsum + (r_s1.mask[s] ? SUM_W'(mean_q[s]) : '0);
        end
        res = r_s1.border ? raw_pix : box_div(vsum, r_s1.win5);
    end

    always_ff @(posedge i_clk) begin
        if (acc && emit) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_o_pixel <= res;
            r_o_last  <= r_s1.last;
        end
    end

    assign o_pix.valid      = r_o_valid;
    assign o_pix.pixel_out  = r_o_pixel;
    assign o_pix.frame_last = r_o_last;

    // With both result slots full and the receiver stalled, no word may enter.
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_o_valid && !o_pix.ready) |-> !acc)
        else $error("word accepted while both result slots are full");

    // The output register is only ever loaded from the read stage.
    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_s1_valid))
        else $error("output became valid without a result in the read stage");

    // Column counters must stay inside the line RAM depth.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LIM_W'(r_in_col) < LIM_W'(MAX_WIDTH)) && (LIM_W'(r_out_col) < LIM_W'(MAX_WIDTH)))
        else $error("column counter beyond line depth");

    // A drain word with nothing owed must not produce a result.
    a_empty_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !pix_acc && (r_pending == '0)) |=> !r_s1_valid)
        else $error("drain word produced a result with nothing pending");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the separable box filter: predicts every filtered word.
module tb_top;
    import sbf_pkg::*;

    localparam int MAX_W         = 2048;
    localparam int WIDE_WIN      = 5;
    localparam int NARROW_WIN    = 3;
    localparam int BACKLOG_LIMIT = 65535;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PIXELS = 150;
    localparam longint TIMEOUT   = 40_000_000;

    typedef struct packed {
        t_pixel pixel;
        logic   frame_end;
    } t_box_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    sbf_in_if  pix_if ();
    sbf_out_if res_if ();

    separable_box_filter #(
        .MAX_WIDTH(MAX_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_pix      (res_if)
    );

    // Predictor state: configuration, horizontal window, line stores and positions.
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_height;
    logic             cfg_win5;
    t_pixel           row_px [TAPS];
    t_pixel           mean_line [MEAN_LINES*MAX_W];
    t_pixel           raw_line [RAW_LINES*MAX_W];
    int unsigned      col_in, row_in, col_out, row_out;
    int unsigned      tag_in, tag_out;
    int unsigned      backlog;

    t_box_result expected_pixels [$];

    int unsigned n_pixels, n_drains, n_ignored, n_checked, n_settings;
    int unsigned errors;
    bit          no_gaps;
    bit          hold_req;
    bit          holding;

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #(TIMEOUT);
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned active_width();
        if (cfg_width < MIN_FRAME) return MIN_FRAME;
        if (cfg_width > MAX_W) return MAX_W;
        return cfg_width;
    endfunction

    function automatic int unsigned active_height();
        if (cfg_height < MIN_FRAME) return MIN_FRAME;
        return cfg_height;
    endfunction

    function automatic int unsigned win_len();
        return (cfg_win5 && WIN5_OK) ? WIDE_WIN : NARROW_WIN;
    endfunction

    function automatic int unsigned line_index(input int unsigned slot, input int unsigned col);
        return slot * MAX_W + (col % MAX_W);
    endfunction

    function automatic void reset_predictor();
        int unsigned i;
        cfg_width  = RST_FRAME_WIDTH;
        cfg_height = RST_FRAME_HEIGHT;
        cfg_win5   = RST_WINDOW_SELECT;
        for (i = 0; i < TAPS; i++) row_px[i] = '0;
        col_in  = 0;
        row_in  = 0;
        col_out = 0;
        row_out = 0;
        tag_in  = 0;
        tag_out = 0;
        backlog = 0;
    endfunction

    // Produces the word for the oldest pending position; newest is the row mean
    // of the row entering the vertical window, zero on a drain.
    function automatic void emit_box_mean(input int unsigned newest);
        int unsigned k, r, w, h, age, raw, val, vsum, i;
        t_box_result res;
        k = win_len();
        r = k / 2;
        w = active_width();
        h = active_height();
        age = backlog - 1;
        if (age < TAPS) raw = row_px[age];
        else raw = raw_line[line_index(tag_out & 1, col_out)];
        if (row_out < r || row_out + r >= h || col_out < r || col_out + r >= w) begin
            val = raw;
        end else begin
            vsum = newest;
            for (i = 0; i < 2 * r; i++)
                vsum += mean_line[line_index((tag_out + 4 - r + i) & 3, col_out)];
            val = vsum / k;
        end
        res.pixel     = t_pixel'(val);
        res.frame_end = (row_out + 1 >= h && col_out + 1 >= w);
        expected_pixels.push_back(res);
        if (col_out + 1 >= w) begin
            col_out = 0;
            tag_out = (tag_out + 1) & 3;
            row_out = (row_out + 1 >= h) ? 0 : row_out + 1;
        end else begin
            col_out++;
        end
        backlog--;
    endfunction

    function automatic void predict_word(input logic kind, input t_pixel pix);
        int unsigned k, r, w, h, lag, hsum, hmean, i;
        k = win_len();
        r = k / 2;
        w = active_width();
        h = active_height();
        lag = r * w + r;
        if (kind == REQ_DRAIN) begin
            n_drains++;
            if (row_in == 0 && col_in == 0 && backlog > 0) emit_box_mean(0);
            else n_ignored++;
            return;
        end
        n_pixels++;
        // The pixel falling out of the five-tap window goes to the raw line store.
        if (col_in >= TAPS) raw_line[line_index(tag_in & 1, col_in - TAPS)] = row_px[TAPS-1];
        else raw_line[line_index((tag_in + 1) & 1, w - TAPS + col_in)] = row_px[TAPS-1];
        for (i = TAPS - 1; i > 0; i--) row_px[i] = row_px[i-1];
        row_px[0] = pix;
        hsum = 0;
        for (i = 0; i < k; i++) hsum += row_px[i];
        hmean = hsum / k;
        if (backlog < BACKLOG_LIMIT) backlog++;
        if (backlog > lag) emit_box_mean(hmean);
        if (col_in + 1 >= k) mean_line[line_index(tag_in & 3, col_in - r)] = t_pixel'(hmean);
        if (col_in + 1 >= w) begin
            col_in = 0;
            tag_in = (tag_in + 1) & 3;
            row_in = (row_in + 1 >= h) ? 0 : row_in + 1;
        end else begin
            col_in++;
        end
    endfunction

    function automatic int unsigned idle_len();
        int unsigned roll;
        if (no_gaps) return 0;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(10, 4);
        return $urandom_range(40, 15);
    endfunction

    function automatic t_pixel random_pixel();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) return 8'h00;
        if (roll < 20) return 8'hFF;
        return t_pixel'($urandom_range(255));
    endfunction

    task automatic send_word(input logic kind, input t_pixel pix);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.req_type <= kind;
        pix_if.pixel_in <= pix;
        do @(posedge i_clk); while (pix_if.ready !== 1'b1);
        predict_word(kind, pix);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_FRAME_WIDTH:   cfg_width = value;
            CFG_FRAME_HEIGHT:  cfg_height = value;
            CFG_WINDOW_SELECT: cfg_win5 = value[0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h, input logic win5);
        cfg_write(CFG_FRAME_WIDTH, CFG_W'(w));
        cfg_write(CFG_FRAME_HEIGHT, CFG_W'(h));
        cfg_write(CFG_WINDOW_SELECT, CFG_W'(win5));
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Sends one whole frame; noise_pct sets the share of stray mid-frame drains.
    task automatic send_frame(input int unsigned noise_pct);
        int unsigned count, n;
        count = active_width() * active_height();
        for (n = 0; n < count; n++) begin
            if (n != 0 && $urandom_range(99) < noise_pct)
                send_word(REQ_DRAIN, t_pixel'($urandom));
            send_word(REQ_PIXEL, random_pixel());
        end
    endtask

    task automatic drain_all();
        while (backlog != 0) send_word(REQ_DRAIN, t_pixel'($urandom));
    endtask

    task automatic settle();
        pix_if.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Minimal frame under the reset window size, with drains that must do nothing.
    task automatic test_directed();
        int unsigned n;
        cfg_write(CFG_FRAME_WIDTH, CFG_W'(5));
        cfg_write(CFG_FRAME_HEIGHT, CFG_W'(5));
        i_cfg_we <= 1'b0;
        n_settings++;
        send_word(REQ_DRAIN, 8'hFF);
        for (n = 0; n < 25; n++) begin
            if (n == 12) send_word(REQ_DRAIN, 8'h00);
            send_word(REQ_PIXEL, (n == 0 || n == 24) ? 8'h00 : (n == 7 ? 8'h01 : 8'hFF));
        end
        drain_all();
        settle();
    endtask

    task automatic test_back_to_back();
        set_frame(7, 5, 1'b0);
        repeat (3) send_frame(0);
        drain_all();
        settle();
    endtask

    task automatic test_backpressure();
        set_frame(16, 6, 1'b1);
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        wait (holding);
        send_frame(0);
        no_gaps = 1'b0;
        drain_all();
        settle();
    endtask

    // Sizes below the minimum, which the block raises to five in each direction.
    task automatic test_extreme_sizes();
        no_gaps = 1'b1;
        set_frame(0, 0, 1'b1);
        send_frame(0);
        drain_all();
        settle();
        set_frame(2, 3, 1'b0);
        send_frame(0);
        drain_all();
        settle();
        no_gaps = 1'b0;
    endtask

    task automatic test_random_frames();
        int unsigned sent, frames, f, w, h, partial;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            no_gaps = ($urandom_range(4) == 0);
            w = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 5);
            h = $urandom_range(8, 5);
            if ($urandom_range(7) == 0) w = $urandom_range(4);
            if ($urandom_range(7) == 0) h = $urandom_range(4);
            set_frame(w, h, 1'($urandom_range(1)));
            frames = $urandom_range(3, 1);
            for (f = 0; f < frames; f++) begin
                send_frame(3);
                sent += active_width() * active_height();
                // Sometimes flush only part of the tail before the next frame starts.
                if (f + 1 < frames && $urandom_range(2) == 0) begin
                    partial = $urandom_range(backlog);
                    repeat (partial) send_word(REQ_DRAIN, t_pixel'($urandom));
                end
            end
            drain_all();
            settle();
        end
        no_gaps = 1'b0;
    endtask

    initial begin : result_sink
        int unsigned stall, run;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                holding = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holding  = 1'b0;
                hold_req = 1'b0;
            end else begin
                stall = idle_len();
                if (stall != 0) begin
                    res_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            res_if.ready <= 1'b1;
            run = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(80, 30);
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin : result_checker
        t_box_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                if (expected_pixels.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual pixel_out %0d frame_last %0b",
                             $time, res_if.pixel_out, res_if.frame_last);
                end else begin
                    want = expected_pixels.pop_front();
                    n_checked++;
                    if (res_if.pixel_out !== want.pixel) begin
                        errors++;
                        $display("%0t: pixel_out expected %0d, actual %0d",
                                 $time, want.pixel, res_if.pixel_out);
                    end
                    if (res_if.frame_last !== want.frame_end) begin
                        errors++;
                        $display("%0t: frame_last expected %0b, actual %0b",
                                 $time, want.frame_end, res_if.frame_last);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        pix_if.valid    <= 1'b0;
        pix_if.req_type <= REQ_PIXEL;
        pix_if.pixel_in <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_FRAME_WIDTH;
        i_cfg_data      <= '0;
        i_rst_n         <= 1'b0;
        reset_predictor();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_back_to_back();
        test_backpressure();
        test_extreme_sizes();
        test_random_frames();
        settle();

        $display("Run covered %0d pixel words and %0d drain words (%0d with no effect), %0d results checked.",
                 n_pixels, n_drains, n_ignored, n_checked);
        $display("It used %0d frame settings: both window sizes, clamped sizes and a long output stall.",
                 n_settings);
        if (errors == 0 && expected_pixels.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

[files.f]
rtl/sbf_pkg.sv
rtl/sbf_in_if.sv
rtl/sbf_out_if.sv
rtl/sbf_ram.sv
rtl/sbf_pixel_cell.sv
rtl/separable_box_filter.sv
tb/tb_top.sv
